// ----- design/ese_pkg.sv -----
// Shared widths, constants and register indexes of the encoder speed estimator.
`default_nettype none

package ese_pkg;

   // Field widths of the sample word.
   localparam int COUNT_BITS = 16;
   localparam int TIME_BITS  = 32;

   // Field widths of the result word.
   localparam int SPEED_BITS = 40;
   localparam int POS_BITS   = 32;

   // Configuration port.
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNTER_TOP    = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSES_PER_REV = 1'd1;

   // Input operation codes.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Counter modulus is counter_top + 1, one bit wider than the register.
   localparam int MOD_BITS = CSR_DATA_BITS + 1;

   // 60 s/min * 1000 ms/s * 256 for the eight fractional bits.
   localparam int SCALE_BITS = 24;
   localparam logic [SCALE_BITS-1:0] SPEED_SCALE = 24'd15360000;

   // Divider operand widths: scale * magnitude over pulses_per_rev * dt.
   localparam int NUM_BITS = SCALE_BITS + MOD_BITS;
   localparam int DEN_BITS = CSR_DATA_BITS + TIME_BITS;

endpackage : ese_pkg

`default_nettype wire

// ----- design/ese_req_if.sv -----
// Sample channel between a source and the speed estimator.
`default_nettype none

interface ese_req_if;
   import ese_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [COUNT_BITS-1:0] counter_sample;
   logic [TIME_BITS-1:0]  time_ms;

   modport source (output valid, output op, output counter_sample, output time_ms,
                   input ready);
   modport sink   (input valid, input op, input counter_sample, input time_ms,
                   output ready);
endinterface : ese_req_if

`default_nettype wire

// ----- design/ese_rsp_if.sv -----
// Result channel from the speed estimator to its consumer.
`default_nettype none

interface ese_rsp_if;
   import ese_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [SPEED_BITS-1:0] speed_rpm_q8;
   logic signed [POS_BITS-1:0]   position_counts;
   logic                         interval_zero;

   modport source (output valid, output speed_rpm_q8, output position_counts,
                   output interval_zero, input ready);
   modport sink   (input valid, input speed_rpm_q8, input position_counts,
                   input interval_zero, output ready);
endinterface : ese_rsp_if

`default_nettype wire

// ----- design/ese_divider.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module ese_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [ese_pkg::NUM_BITS-1:0] dividend,
   input  wire logic [ese_pkg::DEN_BITS-1:0] divisor,
   output logic      [ese_pkg::NUM_BITS-1:0] quotient,
   output logic      [ese_pkg::DEN_BITS-1:0] remainder,
   output logic                              done
);
   import ese_pkg::*;

   localparam int CNT_BITS = $clog2(NUM_BITS);

   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] div_ff, div_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_BITS:0]   trial;
   logic                fits;

   // Shift the next dividend bit into the partial remainder and try a subtract.
   assign trial = {rem_ff, quo_ff[NUM_BITS-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_BITS'(NUM_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_BITS'(trial - {1'b0, div_ff}) : DEN_BITS'(trial);
         quo_in = {quo_ff[NUM_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule : ese_divider

`default_nettype wire

// ----- design/encoder_speed_estimator.sv -----
// Top level of the quadrature encoder speed estimator (M method).
// A speed sample runs through the reductions, the difference, the scaling products and the
// 41 steps of the shared one-bit-per-cycle divider; each reading above counter_top adds a divider pass.
// Clear words, first samples and zero-interval samples go from idle straight to the result stage.
// Throughput: one word at a time; the next is taken once the result is in the output register.
// Synchronous reset restores the register defaults.
`default_nettype none

module encoder_speed_estimator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ese_req_if.sink                                req_bus,
   ese_rsp_if.source                              rsp_bus,
   input  wire logic                              csr_write,
   input  wire logic [ese_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ese_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import ese_pkg::*;

   // The sequencer walks through the reductions, the difference, the two scaling
   // products and the quotient. Only the divider is shared; it serves the modulo
   // reduction of an out-of-range reading as well as the final speed division.
   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_REDC  = 10'b0000000010,
      ST_WAITC = 10'b0000000100,
      ST_REDP  = 10'b0000001000,
      ST_WAITP = 10'b0000010000,
      ST_DIFF  = 10'b0000100000,
      ST_MUL   = 10'b0001000000,
      ST_DIV   = 10'b0010000000,
      ST_WAITQ = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [CSR_DATA_BITS-1:0] top_ff, top_in;
   logic [CSR_DATA_BITS-1:0] ppr_ff, ppr_in;

   // Architectural state.
   logic [COUNT_BITS-1:0] prev_count_ff, prev_count_in;
   logic [TIME_BITS-1:0]  prev_time_ff, prev_time_in;
   logic                  first_ff, first_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;

   // Working registers of the word in flight.
   logic [COUNT_BITS-1:0] cur_ff, cur_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [TIME_BITS-1:0]  dt_ff, dt_in;
   logic [MOD_BITS-1:0]   cr_ff, cr_in;
   logic [MOD_BITS-1:0]   pr_ff, pr_in;
   logic [MOD_BITS-1:0]   mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [NUM_BITS-1:0]   num_ff, num_in;
   logic [DEN_BITS-1:0]   den_ff, den_in;

   // Result staging and the output register.
   logic [SPEED_BITS-1:0] res_speed_ff, res_speed_in;
   logic [POS_BITS-1:0]   res_pos_ff, res_pos_in;
   logic                  res_iz_ff, res_iz_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SPEED_BITS-1:0] rsp_speed_ff, rsp_speed_in;
   logic [POS_BITS-1:0]   rsp_pos_ff, rsp_pos_in;
   logic                  rsp_iz_ff, rsp_iz_in;

   // Divider hookup.
   logic                div_start;
   logic [NUM_BITS-1:0] div_dividend;
   logic [DEN_BITS-1:0] div_divisor;
   logic [NUM_BITS-1:0] div_quotient;
   logic [DEN_BITS-1:0] div_remainder;
   logic                div_done;

   // Helpers.
   logic                  req_take;
   logic [TIME_BITS-1:0]  dt_now;
   logic [MOD_BITS-1:0]   modulus;
   logic [MOD_BITS-1:0]   half;
   logic [MOD_BITS:0]     diff_raw;
   logic [MOD_BITS-1:0]   diff;
   logic                  diff_neg;
   logic [MOD_BITS-1:0]   diff_mag;
   logic                  cur_above;
   logic                  prev_above;
   logic [CSR_DATA_BITS-1:0] ppr_eff;
   logic                  out_free;

   assign req_take   = req_bus.valid && req_bus.ready;
   assign dt_now     = req_bus.time_ms - prev_time_ff;
   assign modulus    = {1'b0, top_ff} + 1'b1;
   assign half       = MOD_BITS'(top_ff >> 1);
   assign cur_above  = NUM_BITS'(cur_ff) > NUM_BITS'(top_ff);
   assign prev_above = NUM_BITS'(prev_count_ff) > NUM_BITS'(top_ff);
   assign ppr_eff    = (ppr_ff == '0) ? CSR_DATA_BITS'(1) : ppr_ff;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;

   // Both reduced readings are below the modulus, so one conditional wrap
   // gives the forward difference. It counts forward up to half the top value.
   assign diff_raw = (cr_ff >= pr_ff) ? ({1'b0, cr_ff} - {1'b0, pr_ff})
                                      : ({1'b0, cr_ff} + {1'b0, modulus} - {1'b0, pr_ff});
   assign diff     = MOD_BITS'(diff_raw);
   assign diff_neg = diff > half;
   assign diff_mag = diff_neg ? (modulus - diff) : diff;

   // The divider sees the reading under reduction or the speed fraction.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = num_ff;
      div_divisor  = den_ff;
      case (state_ff)
         ST_REDC: begin
            div_start    = cur_above;
            div_dividend = NUM_BITS'(cur_ff);
            div_divisor  = DEN_BITS'(modulus);
         end
         ST_REDP: begin
            div_start    = prev_above;
            div_dividend = NUM_BITS'(prev_count_ff);
            div_divisor  = DEN_BITS'(modulus);
         end
         ST_DIV: begin
            div_start = 1'b1;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   ese_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .done      (div_done)
   );

   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      ppr_in        = ppr_ff;
      prev_count_in = prev_count_ff;
      prev_time_in  = prev_time_ff;
      first_in      = first_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      now_in        = now_ff;
      dt_in         = dt_ff;
      cr_in         = cr_ff;
      pr_in         = pr_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      res_speed_in  = res_speed_ff;
      res_pos_in    = res_pos_ff;
      res_iz_in     = res_iz_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_speed_in  = rsp_speed_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_iz_in     = rsp_iz_ff;

      // The user must write configuration only while the block is idle; the block itself does not enforce it.
      if (csr_write) begin
         case (csr_index)
            CSR_COUNTER_TOP:    top_in = csr_data;
            CSR_PULSES_PER_REV: ppr_in = csr_data;
            default: begin
            end
         endcase
      end

      // A result word leaves as soon as the consumer takes it.
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_speed_in = '0;
               res_iz_in    = 1'b0;
               state_in     = ST_DONE;
               if (req_bus.op == OP_CLEAR) begin
                  // Clear: position and stored count go to zero, the time is kept.
                  pos_in        = '0;
                  prev_count_in = '0;
                  first_in      = 1'b1;
                  res_pos_in    = '0;
               end else if (dt_now == '0) begin
                  // Same timestamp as the stored one: flag it and change nothing.
                  res_iz_in  = 1'b1;
                  res_pos_in = pos_ff;
               end else if (first_ff) begin
                  // First sample after reset or a clear only stores the reading and its time.
                  first_in      = 1'b0;
                  prev_count_in = req_bus.counter_sample;
                  prev_time_in  = req_bus.time_ms;
                  res_pos_in    = pos_ff;
               end else begin
                  cur_in   = req_bus.counter_sample;
                  now_in   = req_bus.time_ms;
                  dt_in    = dt_now;
                  state_in = ST_REDC;
               end
            end
         end
         ST_REDC: begin
            if (cur_above) begin
               state_in = ST_WAITC;
            end else begin
               cr_in    = MOD_BITS'(cur_ff);
               state_in = ST_REDP;
            end
         end
         ST_WAITC: begin
            if (div_done) begin
               cr_in    = div_remainder[MOD_BITS-1:0];
               state_in = ST_REDP;
            end
         end
         ST_REDP: begin
            if (prev_above) begin
               state_in = ST_WAITP;
            end else begin
               pr_in    = MOD_BITS'(prev_count_ff);
               state_in = ST_DIFF;
            end
         end
         ST_WAITP: begin
            if (div_done) begin
               pr_in    = div_remainder[MOD_BITS-1:0];
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            // Signed count change goes into the position; the sample becomes the
            // new reference.
            mag_in        = diff_mag;
            neg_in        = diff_neg;
            pos_in        = diff_neg ? (pos_ff - POS_BITS'(diff_mag))
                                     : (pos_ff + POS_BITS'(diff_mag));
            res_pos_in    = diff_neg ? (pos_ff - POS_BITS'(diff_mag))
                                     : (pos_ff + POS_BITS'(diff_mag));
            prev_count_in = cur_ff;
            prev_time_in  = now_ff;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            num_in   = NUM_BITS'(SPEED_SCALE * mag_ff);
            den_in   = DEN_BITS'(ppr_eff * dt_ff);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = ST_WAITQ;
         end
         ST_WAITQ: begin
            if (div_done) begin
               // The quotient is a magnitude; the direction sets the sign.
               res_speed_in = neg_ff ? SPEED_BITS'(~div_quotient + 1'b1)
                                     : SPEED_BITS'(div_quotient);
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = res_speed_ff;
               rsp_pos_in   = res_pos_ff;
               rsp_iz_in    = res_iz_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         top_ff        <= 16'hFFFF;
         ppr_ff        <= 16'd1024;
         prev_count_ff <= '0;
         prev_time_ff  <= '0;
         first_ff      <= 1'b1;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         ppr_ff        <= ppr_in;
         prev_count_ff <= prev_count_in;
         prev_time_ff  <= prev_time_in;
         first_ff      <= first_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      now_ff       <= now_in;
      dt_ff        <= dt_in;
      cr_ff        <= cr_in;
      pr_ff        <= pr_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      res_speed_ff <= res_speed_in;
      res_pos_ff   <= res_pos_in;
      res_iz_ff    <= res_iz_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_iz_ff    <= rsp_iz_in;
   end

   // A new word is taken whenever the sequencer is idle, even while the last
   // result still waits in the output register.
   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.speed_rpm_q8    = rsp_speed_ff;
   assign rsp_bus.position_counts = rsp_pos_ff;
   assign rsp_bus.interval_zero   = rsp_iz_ff;

endmodule : encoder_speed_estimator

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench of the encoder speed estimator: directed and random words checked by a predictor.
`timescale 1ns / 1ps

module testbench;
   import ese_pkg::*;

   // Clock and reset. Reset is held high from time zero until the stimulus process releases it.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   // Channels and configuration port of the block.
   ese_req_if req_ch ();
   ese_rsp_if rsp_ch ();

   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   // Ready of the result side, low until the receiver process first decides.
   logic rsp_ready = 1'b0;

   assign rsp_ch.ready = rsp_ready;

   encoder_speed_estimator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // One minute is 60000 ms, and the speed carries eight fractional bits.
   localparam longint unsigned RPM_Q8_PER_COUNT_MS = 64'd60 * 64'd1000 * 64'd256;

   // Cycles to let pass once nothing is outstanding. A sample whose two readings both
   // lie above counter_top uses the divider three times.
   localparam int PHASE_SETTLE = 4;
   localparam int END_SETTLE   = 160;

   // Length of the long stall of the result side in the backpressure test.
   localparam int LONG_HOLD = 400;

   // One result word as the block should produce it.
   typedef struct {
      logic signed [SPEED_BITS-1:0] speed;
      logic signed [POS_BITS-1:0]   position;
      logic                         interval_zero;
   } estimate_type;

   // Results still owed by the block, oldest first.
   estimate_type pending_estimates[$];

   // Our own copy of the registers, kept at their reset values until written.
   logic [CSR_DATA_BITS-1:0] cfg_counter_top    = 16'hFFFF;
   logic [CSR_DATA_BITS-1:0] cfg_pulses_per_rev = 16'd1024;

   // Our own copy of the estimator state.
   logic [COUNT_BITS-1:0] stored_count  = '0;
   logic [TIME_BITS-1:0]  stored_time   = '0;
   logic                  first_pending = 1'b1;
   logic [POS_BITS-1:0]   position      = '0;

   // Where the random encoder walk currently stands.
   logic [COUNT_BITS-1:0] walk_count = '0;
   logic [TIME_BITS-1:0]  walk_time  = 32'd1000;

   // Idling control shared by both sides, and the handoff for the long result stall.
   logic idle_on       = 1'b1;
   int   hold_requests = 0;
   int   holds_served  = 0;
   int   ready_hold    = 0;

   int mismatch_count = 0;

   // Predicts the result of one accepted word and moves the state on.
   // The zero interval check comes first, so it also applies to a pending first sample.
   function automatic estimate_type advance_estimate(logic op, logic [COUNT_BITS-1:0] reading,
                                                     logic [TIME_BITS-1:0] stamp);
      estimate_type         est;
      logic [TIME_BITS-1:0] interval;
      longint unsigned      modulus, half, now_red, old_red, diff, mag;
      longint unsigned      divisor, quotient, speed_wide;
      logic                 backward;
      est.speed         = '0;
      est.interval_zero = 1'b0;
      if (op == OP_CLEAR) begin
         // The stored time survives a clear; everything else starts over.
         position      = '0;
         stored_count  = '0;
         first_pending = 1'b1;
      end else begin
         interval = stamp - stored_time;
         if (interval == '0) begin
            est.interval_zero = 1'b1;
         end else if (first_pending) begin
            first_pending = 1'b0;
            stored_count  = reading;
            stored_time   = stamp;
         end else begin
            // Both readings are reduced modulo counter_top + 1; the forward direction
            // wins while the raw difference does not exceed half of counter_top.
            modulus  = cfg_counter_top + 64'd1;
            half     = 64'(cfg_counter_top >> 1);
            now_red  = reading % modulus;
            old_red  = stored_count % modulus;
            diff     = (now_red + modulus - old_red) % modulus;
            backward = diff > half;
            mag      = backward ? modulus - diff : diff;
            // A pulses_per_rev of zero scales as one.
            divisor  = (cfg_pulses_per_rev == '0) ? 64'd1 : 64'(cfg_pulses_per_rev);
            divisor  = divisor * 64'(interval);
            quotient = (RPM_Q8_PER_COUNT_MS * mag) / divisor;
            speed_wide = backward ? 64'd0 - quotient : quotient;
            est.speed  = speed_wide[SPEED_BITS-1:0];
            if (backward) begin
               position = position - mag[POS_BITS-1:0];
            end else begin
               position = position + mag[POS_BITS-1:0];
            end
            stored_count = reading;
            stored_time  = stamp;
         end
      end
      est.position = position;
      return est;
   endfunction

   // Gap length in cycles: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (!idle_on || roll < 55) return 0;
      if (roll < 96) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   task automatic report_mismatch(string text);
      $display("ERROR at %0t ns: %s", $time, text);
      mismatch_count++;
   endtask

   // Compares one accepted result word with the oldest prediction, field by field.
   task automatic check_estimate();
      estimate_type want;
      if (pending_estimates.size() == 0) begin
         report_mismatch($sformatf("result word with nothing expected: speed %0d position %0d",
                                   rsp_ch.speed_rpm_q8, rsp_ch.position_counts));
         return;
      end
      want = pending_estimates.pop_front();
      if (rsp_ch.speed_rpm_q8 !== want.speed)
         report_mismatch($sformatf("speed_rpm_q8 is %0d, want %0d",
                                   rsp_ch.speed_rpm_q8, want.speed));
      if (rsp_ch.position_counts !== want.position)
         report_mismatch($sformatf("position_counts is %0d, want %0d",
                                   rsp_ch.position_counts, want.position));
      if (rsp_ch.interval_zero !== want.interval_zero)
         report_mismatch($sformatf("interval_zero is %b, want %b",
                                   rsp_ch.interval_zero, want.interval_zero));
   endtask

   // Result side: check the word taken at this edge, then decide on ready for the next one.
   // A long hold asked for by a test is counted down here, independent of the sender.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         check_estimate();
      end
      if (hold_requests != holds_served) begin
         holds_served = holds_served + 1;
         ready_hold   = LONG_HOLD;
      end
      if (ready_hold > 0) begin
         rsp_ready <= 1'b0;
         ready_hold = ready_hold - 1;
      end else begin
         ready_hold = pick_gap();
         if (ready_hold > 0) begin
            rsp_ready <= 1'b0;
            ready_hold = ready_hold - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one word, waits for it to be taken and records what it should produce.
   // Valid stays high after acceptance, so back-to-back words need no extra assignment.
   task automatic send_word(logic op, logic [COUNT_BITS-1:0] reading,
                            logic [TIME_BITS-1:0] stamp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.op             <= op;
      req_ch.counter_sample <= reading;
      req_ch.time_ms        <= stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_estimates.push_back(advance_estimate(op, reading, stamp));
   endtask

   // Stops offering and waits until every predicted word has come back.
   task automatic wait_drained(int settle);
      req_ch.valid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_COUNTER_TOP) begin
         cfg_counter_top = data;
      end else begin
         cfg_pulses_per_rev = data;
      end
      @(posedge clock);
   endtask

   // Registers are only written with the block idle.
   task automatic configure(logic [CSR_DATA_BITS-1:0] top, logic [CSR_DATA_BITS-1:0] ppr);
      wait_drained(PHASE_SETTLE);
      write_register(CSR_COUNTER_TOP, top);
      write_register(CSR_PULSES_PER_REV, ppr);
   endtask

   // Reset values of the registers, the first sample after reset and after a clear, and
   // zero intervals both while the first sample is pending and after it.
   task automatic test_first_sample_and_clear();
      send_word(OP_SAMPLE, 16'd0, 32'd0);
      send_word(OP_SAMPLE, 16'd100, 32'd5);
      send_word(OP_SAMPLE, 16'd150, 32'd10);
      send_word(OP_SAMPLE, 16'd150, 32'd10);
      send_word(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
      // The clear keeps the stored time, so this interval is still zero.
      send_word(OP_SAMPLE, 16'hFFFF, 32'd10);
      send_word(OP_SAMPLE, 16'hFFFF, 32'd11);
      send_word(OP_CLEAR, 16'd0, 32'd0);
   endtask

   // Both directions, the tie at half of counter_top, the largest step, counter and
   // timestamp wrap, and the longest possible interval.
   task automatic test_direction_and_time_wrap();
      send_word(OP_SAMPLE, 16'd100, 32'd20);
      send_word(OP_SAMPLE, 16'd50, 32'd30);
      send_word(OP_SAMPLE, 16'hFFFF, 32'd31);
      send_word(OP_SAMPLE, 16'd32766, 32'd32);
      send_word(OP_SAMPLE, 16'hFFFF, 32'd33);
      send_word(OP_SAMPLE, 16'd32767, 32'd34);
      send_word(OP_SAMPLE, 16'd32767, 32'hFFFF_FFFF);
      send_word(OP_SAMPLE, 16'd0, 32'd1);
      send_word(OP_SAMPLE, 16'd0, 32'd0);
   endtask

   // Register extremes: a pulses_per_rev of zero, which scales as one, then a counter_top of
   // one and a small even one, both of which bring readings above the top.
   task automatic test_register_extremes();
      configure(16'hFFFF, 16'd0);
      send_word(OP_SAMPLE, 16'd32768, 32'd1);
      send_word(OP_SAMPLE, 16'hFFFF, 32'd2);
      configure(16'd1, 16'hFFFF);
      send_word(OP_SAMPLE, 16'hFFFF, 32'd100);
      send_word(OP_SAMPLE, 16'd4, 32'd200);
      configure(16'd10, 16'd3);
      send_word(OP_SAMPLE, 16'd5, 32'd201);
      send_word(OP_SAMPLE, 16'd10, 32'd202);
      send_word(OP_SAMPLE, 16'd5, 32'd203);
      send_word(OP_SAMPLE, 16'hFFFF, 32'd204);
   endtask

   // Random traffic under the current registers. Most words follow a plausible encoder
   // walk with short intervals; the rest are clears, repeated timestamps, readings above
   // the top, long intervals and fully random words.
   task automatic run_random_phase(int words);
      int                    roll;
      logic                  op;
      logic [COUNT_BITS-1:0] reading;
      logic [TIME_BITS-1:0]  stamp;
      longint unsigned       modulus, limit, mag, base;
      for (int n = 0; n < words; n++) begin
         roll    = $urandom_range(99);
         op      = OP_SAMPLE;
         modulus = cfg_counter_top + 64'd1;
         stamp   = walk_time + (($urandom_range(99) < 85) ? $urandom_range(1, 50)
                                                          : $urandom_range(1, 100000));
         if (roll < 3) begin
            op      = OP_CLEAR;
            reading = COUNT_BITS'($urandom);
            stamp   = $urandom;
         end else if (roll < 7) begin
            reading = COUNT_BITS'($urandom);
            stamp   = walk_time;
         end else if (roll < 11) begin
            reading = COUNT_BITS'($urandom);
            stamp   = $urandom;
         end else if (roll < 14) begin
            reading = walk_count;
            stamp   = walk_time + $urandom;
         end else if (roll < 18 && cfg_counter_top != 16'hFFFF) begin
            reading = COUNT_BITS'($urandom_range(32'(cfg_counter_top) + 32'd1, 32'hFFFF));
         end else begin
            limit = 64'(cfg_counter_top >> 1);
            if (limit > 64'd64 && $urandom_range(99) < 80) limit = 64'd64;
            mag = 64'($urandom_range(0, 32'(limit)));
            // Now and then land right on the tie or just past it.
            if ($urandom_range(9) == 0)
               mag = 64'(cfg_counter_top >> 1) + 64'($urandom_range(0, 1));
            base = walk_count % modulus;
            if ($urandom_range(1)) begin
               reading = COUNT_BITS'((base + modulus - (mag % modulus)) % modulus);
            end else begin
               reading = COUNT_BITS'((base + mag) % modulus);
            end
         end
         send_word(op, reading, stamp);
         if (op == OP_SAMPLE) begin
            walk_count = reading;
            walk_time  = stamp;
         end
      end
   endtask

   // The result side stalls for a long stretch while words keep coming, so the block
   // fills up and has to hold its input off.
   task automatic test_backpressure();
      configure(16'hFFFF, 16'd500);
      idle_on = 1'b0;
      hold_requests = hold_requests + 1;
      run_random_phase(24);
      wait_drained(PHASE_SETTLE);
      idle_on = 1'b1;
   endtask

   // Random traffic under several register settings, the extremes among them, with one
   // phase that runs without any idling.
   task automatic test_random_traffic();
      configure(16'hFFFF, 16'd1024);
      run_random_phase(300);
      configure(16'd1, 16'd1);
      run_random_phase(200);
      configure(CSR_DATA_BITS'($urandom_range(2, 16'hFFFE)),
                CSR_DATA_BITS'($urandom_range(1, 16'hFFFF)));
      run_random_phase(300);
      configure(16'hFFFF, 16'hFFFF);
      idle_on = 1'b0;
      run_random_phase(250);
      wait_drained(PHASE_SETTLE);
      idle_on = 1'b1;
      configure(CSR_DATA_BITS'($urandom_range(2, 40)), CSR_DATA_BITS'($urandom_range(1, 16)));
      run_random_phase(300);
      configure(CSR_DATA_BITS'($urandom_range(2, 16'hFFFE)),
                CSR_DATA_BITS'($urandom_range(1, 16'hFFFF)));
      run_random_phase(330);
   endtask

   initial begin
      req_ch.valid          <= 1'b0;
      req_ch.op             <= OP_SAMPLE;
      req_ch.counter_sample <= '0;
      req_ch.time_ms        <= '0;
      csr_write             <= 1'b0;
      csr_index             <= CSR_COUNTER_TOP;
      csr_data              <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_first_sample_and_clear();
      test_direction_and_time_wrap();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();

      // Everything predicted must be back; stray words after that are flagged by the checker.
      wait_drained(END_SETTLE);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Backstop against a block that stops answering.
   initial begin
      #40ms;
      $display("Mismatches found");
      $finish;
   end

endmodule : testbench
